// ----- rtl/mxf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mxf_pkg;

   // Widths fixed by the result and configuration formats.
   localparam int VAL_W = 16;
   localparam int IDX_W = 10;
   localparam int COL_W = 10;
   localparam int ROW_W = 11;
   localparam int DIM_W = 11;

endpackage

`default_nettype wire

// ----- rtl/max_filter_3x3_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 maximum filter over a square frame of dim x dim pixels.
// Pixels enter in raster order on the req_ channel (valid/ready); after the
// frame, dim further transfers with any value flush the last row.
// Results leave on the rsp_ channel in raster order, each with its row and
// column, a flag on the last result of its input transfer and a flag on the
// bottom-right position. An input at column c gives the result for column
// c-1 of the row above, plus column c itself at the last column.
// The results of a transfer pass through the line store stage, the window
// stage and the output register. Throughput is one transfer per cycle while
// rsp_ready stays high; a transfer at the last column emits two results and
// so holds the pipeline, as the single output register takes one result per cycle.
// After reset the line stores are swept to zero, one address per cycle, over
// all MAX_DIM addresses while req_ready stays low; dim resets to min(MAX_DIM, 1024).
// csr_wr_data, clipped to 1..MAX_DIM, goes into dim at any edge with csr_wr_en high.
// When the receiver stalls the output register holds and the stall backs up
// through the window stage to req_ready, so nothing is lost or repeated.
module max_filter_3x3_top #(
   parameter int MAX_DIM    = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [PIXEL_BITS-1:0]       req_pixel_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [mxf_pkg::VAL_W-1:0]        rsp_max_value,
   output logic [mxf_pkg::IDX_W-1:0]        rsp_out_row,
   output logic [mxf_pkg::IDX_W-1:0]        rsp_out_col,
   output logic                             rsp_last_in_run,
   output logic                             rsp_end_of_frame,
   input  wire logic                        csr_wr_en,
   input  wire logic [mxf_pkg::DIM_W-1:0]   csr_wr_data
);

   import mxf_pkg::*;

   localparam int AW     = $clog2(MAX_DIM);
   localparam int MW     = 2 * PIXEL_BITS;
   localparam int DIM_RV = (MAX_DIM < 1024) ? MAX_DIM : 1024;

   // Configuration
   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [DIM_W-1:0] dim_m1_ff, dim_m1_in;
   logic [DIM_W-1:0] dim_sat;

   // Reset sweep of the line stores
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Position counters
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // Entry stage
   logic                  accept;
   logic                  last_col0, drain0, in_range0, hit0;
   logic [PIXEL_BITS-1:0] pix0;
   logic [AW-1:0]         addr0;

   // Line store stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic                  s1_last_ff, s1_drain_ff, s1_in_range_ff, s1_hit_ff;
   logic [AW-1:0]         s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [MW-1:0]         s1_fwd_ff;
   logic                  s1_go;
   logic [MW-1:0]         mem_rd, line_word, wr_word;
   logic [PIXEL_BITS-1:0] a_raw, b_raw, top_pix, mid_pix, tm_max, col_new;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [MW-1:0]         mem_wr_data;

   // Window stage
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_first_done_ff, s2_first_done_in;
   logic [ROW_W-1:0]      s2_row_ff;
   logic [COL_W-1:0]      s2_col_ff;
   logic                  s2_last_ff, s2_drain_ff;
   logic                  has_first, has_second, s2_finish, adv;
   logic [PIXEL_BITS-1:0] win_q [3];
   logic [PIXEL_BITS-1:0] win_d [3];
   logic                  win_clr [3];
   logic [PIXEL_BITS-1:0] part_max, full_max;
   logic [ROW_W-1:0]      row_m1;
   logic [COL_W-1:0]      col_m1;

   // Output register
   logic                  out_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]      rsp_value_ff;
   logic [IDX_W-1:0]      rsp_row_ff, rsp_col_ff;
   logic                  rsp_last_ff, rsp_eof_ff;

   // ---------------------------------------------------------------------
   // Configuration: the stored side length is already clipped to 1..MAX_DIM.
   always_comb begin
      dim_sat = csr_wr_data;
      if (csr_wr_data == '0) begin
         dim_sat = DIM_W'(1);
      end else if (32'(csr_wr_data) > MAX_DIM) begin
         dim_sat = DIM_W'(MAX_DIM);
      end
      dim_in    = csr_wr_en ? dim_sat : dim_ff;
      dim_m1_in = csr_wr_en ? DIM_W'(dim_sat - DIM_W'(1)) : dim_m1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_W'(DIM_RV);
         dim_m1_ff <= DIM_W'(DIM_RV - 1);
      end else begin
         dim_ff    <= dim_in;
         dim_m1_ff <= dim_m1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Reset sweep
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_DIM - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------------
   // Entry: classify the position, read the line stores, step the counters.
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || adv);
   assign accept    = req_valid && req_ready;

   always_comb begin
      last_col0 = {1'b0, col_ff} >= dim_m1_ff;
      drain0    = row_ff >= dim_ff;
      in_range0 = 32'(col_ff) < MAX_DIM;
      pix0      = drain0 ? '0 : req_pixel_value;
      addr0     = AW'(col_ff);
      // The item ahead writes its word at this same edge, so take it directly.
      hit0      = s1_valid_ff && s1_in_range_ff && in_range0 && (s1_addr_ff == addr0);
      row_in    = row_ff;
      col_in    = col_ff;
      if (accept) begin
         if (last_col0) begin
            col_in = '0;
            row_in = drain0 ? '0 : ROW_W'(row_ff + ROW_W'(1));
         end else begin
            col_in = COL_W'(col_ff + COL_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line store stage
   mxf_line_mem #(
      .DEPTH  (MAX_DIM),
      .DATA_W (MW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (addr0),
      .rd_data (mem_rd),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign s1_go = s1_valid_ff && adv;

   always_comb begin
      line_word = s1_hit_ff ? s1_fwd_ff : mem_rd;
      a_raw     = line_word[PIXEL_BITS-1:0];
      b_raw     = line_word[MW-1:PIXEL_BITS];
      top_pix   = (s1_in_range_ff && (s1_row_ff >= ROW_W'(2))) ? b_raw : '0;
      mid_pix   = (s1_in_range_ff && (s1_row_ff != '0)) ? a_raw : '0;
      tm_max    = (top_pix > mid_pix) ? top_pix : mid_pix;
      col_new   = (tm_max > s1_pix_ff) ? tm_max : s1_pix_ff;
      // The newer row moves down into the older one and the pixel takes its place.
      wr_word   = {a_raw, s1_pix_ff};
      if (clr_busy_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = s1_go && s1_in_range_ff;
         mem_wr_addr = s1_addr_ff;
         mem_wr_data = wr_word;
      end
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_ff     <= last_col0;
         s1_drain_ff    <= drain0;
         s1_in_range_ff <= in_range0;
         s1_addr_ff     <= addr0;
         s1_pix_ff      <= pix0;
         s1_hit_ff      <= hit0;
         s1_fwd_ff      <= wr_word;
      end
   end

   // ---------------------------------------------------------------------
   // Window stage: three column cells shift by one on every item.
   for (genvar i = 0; i < 3; i++) begin : g_win
      if (i == 2) begin : g_head
         assign win_d[i]   = col_new;
         assign win_clr[i] = 1'b0;
      end else begin : g_body
         assign win_d[i]   = win_q[i+1];
         assign win_clr[i] = (s1_col_ff == '0);
      end
      mxf_cell #(
         .W (PIXEL_BITS)
      ) u_cell (
         .clock (clock),
         .load  (s1_go),
         .clear (win_clr[i]),
         .din   (win_d[i]),
         .q     (win_q[i])
      );
   end

   always_comb begin
      part_max   = (win_q[1] > win_q[2]) ? win_q[1] : win_q[2];
      full_max   = (win_q[0] > part_max) ? win_q[0] : part_max;
      row_m1     = ROW_W'(s2_row_ff - ROW_W'(1));
      col_m1     = COL_W'(s2_col_ff - COL_W'(1));
      has_first  = (s2_row_ff != '0) && (s2_col_ff != '0) && !s2_first_done_ff;
      has_second = (s2_row_ff != '0) && s2_last_ff;
      out_load   = s2_valid_ff && (has_first || has_second) &&
                   (!rsp_valid_ff || rsp_ready);
      s2_finish  = s2_valid_ff &&
                   (!(has_first || has_second) || (out_load && !(has_first && has_second)));
      adv        = !s2_valid_ff || s2_finish;

      s2_valid_in      = s1_go ? 1'b1 : (s2_finish ? 1'b0 : s2_valid_ff);
      s2_first_done_in = s2_first_done_ff;
      if (s1_go || s2_finish) begin
         s2_first_done_in = 1'b0;
      end else if (out_load && has_first) begin
         s2_first_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff      <= 1'b0;
         s2_first_done_ff <= 1'b0;
      end else begin
         s2_valid_ff      <= s2_valid_in;
         s2_first_done_ff <= s2_first_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_last_ff  <= s1_last_ff;
         s2_drain_ff <= s1_drain_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   assign rsp_valid_in = out_load ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_row_ff <= row_m1[IDX_W-1:0];
         if (has_first) begin
            rsp_value_ff <= VAL_W'(full_max);
            rsp_col_ff   <= col_m1;
            rsp_last_ff  <= !s2_last_ff;
            rsp_eof_ff   <= 1'b0;
         end else begin
            rsp_value_ff <= VAL_W'(part_max);
            rsp_col_ff   <= s2_col_ff;
            rsp_last_ff  <= 1'b1;
            rsp_eof_ff   <= s2_drain_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_last_in_run  = rsp_last_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

`ifndef SYNTH
   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("input accepted during line store sweep");

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer did not reach the line store stage");

   a_first_done_held : assert property (@(posedge clock) disable iff (reset)
      s2_first_done_ff |-> (s2_valid_ff && s2_last_ff))
      else $error("split result state without a last-column item");

   a_eof_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eof_ff) |-> rsp_last_ff)
      else $error("end of frame on a result that is not last of its transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/mxf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One column of the 3x3 window, held as the maximum of its three pixels.
module mxf_cell #(
   parameter int W = 16
) (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire logic         clear,
   input  wire logic [W-1:0] din,
   output logic      [W-1:0] q
);

   logic [W-1:0] q_ff;
   logic [W-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      if (load) begin
         q_in = clear ? '0 : din;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ----- rtl/mxf_line_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Both line stores side by side: each word holds the older row above the newer one.
module mxf_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
